@@ hw/rtl/alu8f_pkg.sv @@
// alu8f_pkg: operation codes, flag positions and word types of the 8-bit ALU.
// No dependencies; used by alu8f_exec and cpu_alu_8bit_with_flags_core.
package alu8f_pkg;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_AND  = 5'd4,
    OP_XOR  = 5'd5,
    OP_OR   = 5'd6,
    OP_CP   = 5'd7,
    OP_INC  = 5'd8,
    OP_DEC  = 5'd9,
    OP_RLC  = 5'd10,
    OP_RRC  = 5'd11,
    OP_RL   = 5'd12,
    OP_RR   = 5'd13,
    OP_SLA  = 5'd14,
    OP_SRA  = 5'd15,
    OP_SRL  = 5'd16,
    OP_SWAP = 5'd17,
    OP_BIT  = 5'd18,
    OP_SET  = 5'd19,
    OP_RES  = 5'd20
  } alu_op_t;

  // flag nibble bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef struct packed {
    logic [4:0] operation;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic [2:0] bit_index;
    logic [3:0] flags_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] result_value;
    logic [3:0] flags_out;
  } out_word_t;

endpackage

@@ hw/rtl/alu8f_if.sv @@
// alu8f_in_if / alu8f_out_if: valid/ready channels of the 8-bit ALU.
// No dependencies.
interface alu8f_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] operation;
  logic [7:0] operand_a;
  logic [7:0] operand_b;
  logic [2:0] bit_index;
  logic [3:0] flags_in;

  modport source (output valid, operation, operand_a, operand_b, bit_index, flags_in,
                  input ready);
  modport sink   (input valid, operation, operand_a, operand_b, bit_index, flags_in,
                  output ready);
endinterface

interface alu8f_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_value;
  logic [3:0] flags_out;

  modport source (output valid, result_value, flags_out, input ready);
  modport sink   (input valid, result_value, flags_out, output ready);
endinterface

@@ hw/rtl/alu8f_exec.sv @@
// alu8f_exec: combinational datapath, one word in, result and flags out.
// Depends on alu8f_pkg.
module alu8f_exec (
  input  alu8f_pkg::in_word_t  in_word,
  output alu8f_pkg::out_word_t out_word
);

  logic [7:0] a;
  logic [7:0] b;
  logic [2:0] n;
  logic [3:0] f;
  logic       cy;
  logic       cin;
  logic [8:0] sum;
  logic [4:0] sum_lo;
  logic [8:0] dif;
  logic [4:0] dif_lo;
  logic [7:0] mask;
  logic [7:0] r;
  logic [3:0] fo;

  assign a    = in_word.operand_a;
  assign b    = in_word.operand_b;
  assign n    = in_word.bit_index;
  assign f    = in_word.flags_in;
  assign cy   = f[alu8f_pkg::FLAG_C];
  assign mask = 8'd1 << n;

  // carry in only for adc / sbc
  assign cin = ((in_word.operation == alu8f_pkg::OP_ADC) ||
                (in_word.operation == alu8f_pkg::OP_SBC)) ? cy : 1'b0;

  assign sum    = {1'b0, a} + {1'b0, b} + {8'd0, cin};
  assign sum_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
  // bit 8 / bit 4 set means borrow
  assign dif    = {1'b0, a} - {1'b0, b} - {8'd0, cin};
  assign dif_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};

  always_comb begin
    r  = a;
    fo = f;
    case (alu8f_pkg::alu_op_t'(in_word.operation))
      alu8f_pkg::OP_ADD, alu8f_pkg::OP_ADC: begin
        r  = sum[7:0];
        fo = {(sum[7:0] == 8'd0), 1'b0, sum_lo[4], sum[8]};
      end
      alu8f_pkg::OP_SUB, alu8f_pkg::OP_SBC: begin
        r  = dif[7:0];
        fo = {(dif[7:0] == 8'd0), 1'b1, dif_lo[4], dif[8]};
      end
      alu8f_pkg::OP_CP: begin
        fo = {(dif[7:0] == 8'd0), 1'b1, dif_lo[4], dif[8]};
      end
      alu8f_pkg::OP_AND: begin
        r  = a & b;
        fo = {((a & b) == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      alu8f_pkg::OP_XOR: begin
        r  = a ^ b;
        fo = {((a ^ b) == 8'd0), 3'b000};
      end
      alu8f_pkg::OP_OR: begin
        r  = a | b;
        fo = {((a | b) == 8'd0), 3'b000};
      end
      alu8f_pkg::OP_INC: begin
        r  = a + 8'd1;
        fo = {(a == 8'hFF), 1'b0, (a[3:0] == 4'hF), cy};
      end
      alu8f_pkg::OP_DEC: begin
        r  = a - 8'd1;
        fo = {(a == 8'h01), 1'b1, (a[3:0] == 4'h0), cy};
      end
      alu8f_pkg::OP_RLC: begin
        r  = {a[6:0], a[7]};
        fo = {(a == 8'd0), 2'b00, a[7]};
      end
      alu8f_pkg::OP_RRC: begin
        r  = {a[0], a[7:1]};
        fo = {(a == 8'd0), 2'b00, a[0]};
      end
      alu8f_pkg::OP_RL: begin
        r  = {a[6:0], cy};
        fo = {({a[6:0], cy} == 8'd0), 2'b00, a[7]};
      end
      alu8f_pkg::OP_RR: begin
        r  = {cy, a[7:1]};
        fo = {({cy, a[7:1]} == 8'd0), 2'b00, a[0]};
      end
      alu8f_pkg::OP_SLA: begin
        r  = {a[6:0], 1'b0};
        fo = {(a[6:0] == 7'd0), 2'b00, a[7]};
      end
      alu8f_pkg::OP_SRA: begin
        r  = {a[7], a[7:1]};
        fo = {(a[7:1] == 7'd0), 2'b00, a[0]};
      end
      alu8f_pkg::OP_SRL: begin
        r  = {1'b0, a[7:1]};
        fo = {(a[7:1] == 7'd0), 2'b00, a[0]};
      end
      alu8f_pkg::OP_SWAP: begin
        r  = {a[3:0], a[7:4]};
        fo = {(a == 8'd0), 3'b000};
      end
      alu8f_pkg::OP_BIT: begin
        fo = {~a[n], 1'b0, 1'b1, cy};
      end
      alu8f_pkg::OP_SET: begin
        r = a | mask;
      end
      alu8f_pkg::OP_RES: begin
        r = a & ~mask;
      end
      default: begin
        // undefined codes act as no-operation
        r  = a;
        fo = f;
      end
    endcase
  end

  assign out_word.result_value = r;
  assign out_word.flags_out    = fo;

endmodule

@@ hw/rtl/cpu_alu_8bit_with_flags_core.sv @@
// cpu_alu_8bit_with_flags_core: top level of the 8-bit ALU with Z/N/H/C flags.
// Depends on alu8f_pkg, alu8f_in_if / alu8f_out_if and alu8f_exec.
//
// Usage:
//   in_ch  carries one word per handshake: operation, operand_a, operand_b,
//          bit_index and flags_in. A word is taken when valid and ready are
//          both high at a rising clk edge.
//   out_ch returns exactly one word per input word, in order: result_value
//          and flags_out.
// Path: a taken word passes the input register, then the ALU logic, then the
//          result register, which drives out_ch.
// Throughput: one word per cycle while out_ch.ready stays high; the
//          combinational ALU path lies between the two registers.
// Reset (rst_n low, synchronous): both stages are emptied, out_ch.valid
//          drops and in_ch.ready rises on the next cycle.
// Stall: when out_ch.ready is low the result register holds its word; the
//          input register still takes one more word, so in_ch.ready only
//          falls when both stages are full.
module cpu_alu_8bit_with_flags_core (
  input  logic                clk,
  input  logic                rst_n,
  alu8f_in_if.sink            in_ch,
  alu8f_out_if.source         out_ch
);

  // stage 1: input register
  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  alu8f_pkg::in_word_t  s1_word_r;
  // stage 2: result register
  logic                 s2_valid_r;
  logic                 s2_valid_nxt;
  alu8f_pkg::out_word_t s2_word_r;

  alu8f_pkg::in_word_t  in_word;
  alu8f_pkg::out_word_t exec_word;
  logic                 s2_free;
  logic                 s1_free;
  logic                 in_take;
  logic                 s1_move;

  assign in_word.operation = in_ch.operation;
  assign in_word.operand_a = in_ch.operand_a;
  assign in_word.operand_b = in_ch.operand_b;
  assign in_word.bit_index = in_ch.bit_index;
  assign in_word.flags_in  = in_ch.flags_in;

  // a stage can load when it is empty or its word leaves this cycle
  assign s2_free = !s2_valid_r || out_ch.ready;
  assign s1_free = !s1_valid_r || s2_free;
  assign s1_move = s1_valid_r && s2_free;
  assign in_take = in_ch.valid && s1_free;

  assign in_ch.ready = s1_free;

  alu8f_exec u_exec (
    .in_word  (s1_word_r),
    .out_word (exec_word)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_free) begin
      s1_valid_nxt = in_ch.valid;
    end
    s2_valid_nxt = s2_valid_r;
    if (s2_free) begin
      s2_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_word;
    end
    if (s1_move) begin
      s2_word_r <= exec_word;
    end
  end

  assign out_ch.valid        = s2_valid_r;
  assign out_ch.result_value = s2_word_r.result_value;
  assign out_ch.flags_out    = s2_word_r.flags_out;

endmodule

@@ sim/tb_cpu_alu_8bit_with_flags_core.sv @@
// tb_cpu_alu_8bit_with_flags_core: self-checking testbench for the 8-bit ALU core.
// Depends on alu8f_pkg, alu8f_in_if / alu8f_out_if and cpu_alu_8bit_with_flags_core.
// Directed corner words, then random words under four idle/stall phases.
module tb_cpu_alu_8bit_with_flags_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORDS_PER_PHASE = 325;

  logic clk;
  logic rst_n;

  alu8f_in_if  in_ch ();
  alu8f_out_if out_ch ();

  cpu_alu_8bit_with_flags_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // words waiting to be offered, and ALU results predicted for accepted words
  alu8f_pkg::in_word_t  pending_words[$];
  alu8f_pkg::out_word_t predicted_results[$];

  int unsigned mismatch_count = 0;

  // percent of cycles in which the sender idles / the receiver stalls
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // place Z, N, H, C at their positions in the flag nibble
  function automatic logic [3:0] pack_flags(logic z, logic n, logic h, logic c);
    logic [3:0] f;
    f                    = '0;
    f[alu8f_pkg::FLAG_Z] = z;
    f[alu8f_pkg::FLAG_N] = n;
    f[alu8f_pkg::FLAG_H] = h;
    f[alu8f_pkg::FLAG_C] = c;
    return f;
  endfunction

  function automatic alu8f_pkg::out_word_t alu_result_of(alu8f_pkg::in_word_t w);
    alu8f_pkg::out_word_t res;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] r;
    logic [3:0] fo;
    logic [8:0] wide;
    logic [4:0] nib;
    logic       cy;
    logic       cin;
    a   = w.operand_a;
    b   = w.operand_b;
    cy  = w.flags_in[alu8f_pkg::FLAG_C];
    r   = a;
    fo  = w.flags_in;  // set, res and undefined codes pass flags through
    case (w.operation)
      alu8f_pkg::OP_ADD, alu8f_pkg::OP_ADC: begin
        cin  = (w.operation == alu8f_pkg::OP_ADC) ? cy : 1'b0;
        wide = {1'b0, a} + {1'b0, b} + 9'(cin);
        nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(cin);
        r    = wide[7:0];
        fo   = pack_flags(r == 8'h00, 1'b0, nib[4], wide[8]);
      end
      alu8f_pkg::OP_SUB, alu8f_pkg::OP_SBC, alu8f_pkg::OP_CP: begin
        // bit 8 / bit 4 of the widened difference is the borrow
        cin  = (w.operation == alu8f_pkg::OP_SBC) ? cy : 1'b0;
        wide = {1'b0, a} - {1'b0, b} - 9'(cin);
        nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - 5'(cin);
        fo   = pack_flags(wide[7:0] == 8'h00, 1'b1, nib[4], wide[8]);
        r    = (w.operation == alu8f_pkg::OP_CP) ? a : wide[7:0];
      end
      alu8f_pkg::OP_AND: begin
        r  = a & b;
        fo = pack_flags(r == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      alu8f_pkg::OP_XOR: begin
        r  = a ^ b;
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      alu8f_pkg::OP_OR: begin
        r  = a | b;
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      alu8f_pkg::OP_INC: begin
        r  = a + 8'd1;
        fo = pack_flags(r == 8'h00, 1'b0, a[3:0] == 4'hF, cy);
      end
      alu8f_pkg::OP_DEC: begin
        r  = a - 8'd1;
        fo = pack_flags(r == 8'h00, 1'b1, a[3:0] == 4'h0, cy);
      end
      alu8f_pkg::OP_RLC: begin
        r  = {a[6:0], a[7]};
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, a[7]);
      end
      alu8f_pkg::OP_RRC: begin
        r  = {a[0], a[7:1]};
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, a[0]);
      end
      alu8f_pkg::OP_RL: begin
        r  = {a[6:0], cy};
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, a[7]);
      end
      alu8f_pkg::OP_RR: begin
        r  = {cy, a[7:1]};
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, a[0]);
      end
      alu8f_pkg::OP_SLA: begin
        r  = {a[6:0], 1'b0};
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, a[7]);
      end
      alu8f_pkg::OP_SRA: begin
        r  = {a[7], a[7:1]};
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, a[0]);
      end
      alu8f_pkg::OP_SRL: begin
        r  = {1'b0, a[7:1]};
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, a[0]);
      end
      alu8f_pkg::OP_SWAP: begin
        r  = {a[3:0], a[7:4]};
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      alu8f_pkg::OP_BIT: begin
        fo = pack_flags(~a[w.bit_index], 1'b0, 1'b1, cy);
      end
      alu8f_pkg::OP_SET: r = a | (8'd1 << w.bit_index);
      alu8f_pkg::OP_RES: r = a & ~(8'd1 << w.bit_index);
      default: ;
    endcase
    res.result_value = r;
    res.flags_out    = fo;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_word(logic [4:0] op, logic [7:0] a, logic [7:0] b,
                            logic [2:0] idx, logic [3:0] f);
    alu8f_pkg::in_word_t w;
    w.operation = op;
    w.operand_a = a;
    w.operand_b = b;
    w.bit_index = idx;
    w.flags_in  = f;
    pending_words.push_back(w);
  endtask

  // operands lean on the values where carries, borrows and zero happen
  function automatic logic [7:0] pick_operand();
    if ($urandom_range(3) != 0) return 8'($urandom_range(255));
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h0F;
      3: return 8'hF0;
      4: return 8'h80;
      5: return 8'h01;
      6: return 8'h7F;
      default: return 8'h10;
    endcase
  endfunction

  task automatic queue_random_words(int unsigned count);
    logic [4:0] op;
    for (int unsigned i = 0; i < count; i++) begin
      // mostly defined codes, a few undefined ones (behave as no-op)
      if ($urandom_range(15) == 0) op = 5'($urandom_range(31, 21));
      else                         op = 5'($urandom_range(20));
      queue_word(op, pick_operand(), pick_operand(), 3'($urandom_range(7)),
                 4'($urandom_range(15)));
    end
  endtask

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers the head of pending_words; valid holds until the word
  // is taken, then either the next word follows or a gap is inserted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        alu8f_pkg::in_word_t w;
        w = pending_words.pop_front();
        in_ch.operation <= w.operation;
        in_ch.operand_a <= w.operand_a;
        in_ch.operand_b <= w.operand_b;
        in_ch.bit_index <= w.bit_index;
        in_ch.flags_in  <= w.flags_in;
        in_ch.valid     <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: result side is checked before the input side is recorded, so a
  // stray result word can never be matched against a word taken this edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result word", out_ch.result_value, 8'h00);
        end else begin
          alu8f_pkg::out_word_t want;
          want = predicted_results.pop_front();
          if (out_ch.result_value !== want.result_value)
            report_mismatch("result_value", out_ch.result_value, want.result_value);
          if (out_ch.flags_out !== want.flags_out)
            report_mismatch("flags_out", 8'(out_ch.flags_out), 8'(want.flags_out));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        alu8f_pkg::in_word_t w;
        w.operation = in_ch.operation;
        w.operand_a = in_ch.operand_a;
        w.operand_b = in_ch.operand_b;
        w.bit_index = in_ch.bit_index;
        w.flags_in  = in_ch.flags_in;
        predicted_results.push_back(alu_result_of(w));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  task automatic drain();
    // valid low seen at an edge means the last taken word is already recorded
    while (pending_words.size() != 0 || in_ch.valid || predicted_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    // known levels on every block input before the first edge
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    in_ch.bit_index = '0;
    in_ch.flags_in  = '0;
    out_ch.ready    = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // phase 0: directed corners, then random, back to back with no idling.
    // queue and idle settings change on the falling edge, away from the drivers.
    @(negedge clk);
    queue_word(alu8f_pkg::OP_ADD,  8'hFF, 8'h01, 3'd0, 4'h0);  // zero, half and full carry
    queue_word(alu8f_pkg::OP_ADD,  8'h00, 8'h00, 3'd7, 4'hF);  // zero result, flags ignored
    queue_word(alu8f_pkg::OP_ADC,  8'h0F, 8'h00, 3'd0, 4'h1);  // carry-in makes half carry
    queue_word(alu8f_pkg::OP_ADC,  8'hFF, 8'hFF, 3'd0, 4'h1);  // largest sum
    queue_word(alu8f_pkg::OP_SUB,  8'h5A, 8'h5A, 3'd0, 4'h0);  // equal operands
    queue_word(alu8f_pkg::OP_SUB,  8'h10, 8'h01, 3'd0, 4'h0);  // nibble borrow only
    queue_word(alu8f_pkg::OP_SUB,  8'h00, 8'hFF, 3'd0, 4'h0);  // full borrow
    queue_word(alu8f_pkg::OP_SBC,  8'h00, 8'h00, 3'd0, 4'h1);  // borrow from carry-in
    queue_word(alu8f_pkg::OP_SBC,  8'hFF, 8'hFF, 3'd0, 4'h1);
    queue_word(alu8f_pkg::OP_AND,  8'hF0, 8'h0F, 3'd0, 4'hF);
    queue_word(alu8f_pkg::OP_XOR,  8'hFF, 8'hFF, 3'd0, 4'hF);
    queue_word(alu8f_pkg::OP_OR,   8'h00, 8'h00, 3'd0, 4'h0);
    queue_word(alu8f_pkg::OP_CP,   8'h40, 8'h41, 3'd0, 4'h0);  // A must come back unchanged
    queue_word(alu8f_pkg::OP_INC,  8'hFF, 8'h00, 3'd0, 4'h1);  // wrap, carry kept
    queue_word(alu8f_pkg::OP_DEC,  8'h00, 8'h00, 3'd0, 4'h0);  // wrap, nibble borrow
    queue_word(alu8f_pkg::OP_RLC,  8'h80, 8'h00, 3'd0, 4'h0);
    queue_word(alu8f_pkg::OP_RRC,  8'h01, 8'h00, 3'd0, 4'hE);
    queue_word(alu8f_pkg::OP_RL,   8'h80, 8'h00, 3'd0, 4'h0);  // shifts out to zero
    queue_word(alu8f_pkg::OP_RR,   8'h01, 8'h00, 3'd0, 4'h1);  // carry into bit 7
    queue_word(alu8f_pkg::OP_SLA,  8'h80, 8'h00, 3'd0, 4'hF);
    queue_word(alu8f_pkg::OP_SRA,  8'h81, 8'h00, 3'd0, 4'h0);  // sign bit kept
    queue_word(alu8f_pkg::OP_SRL,  8'h01, 8'h00, 3'd0, 4'h0);
    queue_word(alu8f_pkg::OP_SWAP, 8'hA5, 8'h00, 3'd0, 4'hF);
    queue_word(alu8f_pkg::OP_BIT,  8'h7F, 8'h00, 3'd7, 4'h1);  // tested bit clear
    queue_word(alu8f_pkg::OP_SET,  8'h00, 8'h00, 3'd7, 4'hA);  // flags pass through
    queue_word(alu8f_pkg::OP_RES,  8'hFF, 8'h00, 3'd0, 4'h5);
    queue_word(5'd31,              8'hC3, 8'h3C, 3'd5, 4'h9);  // undefined code, no-op
    queue_random_words(WORDS_PER_PHASE);
    drain();

    // phase 1: sender idle most cycles
    @(negedge clk);
    send_gap_pct   = 72;
    recv_stall_pct = 0;
    queue_random_words(WORDS_PER_PHASE);
    drain();

    // phase 2: receiver stalls most cycles
    @(negedge clk);
    send_gap_pct   = 0;
    recv_stall_pct = 72;
    queue_random_words(WORDS_PER_PHASE);
    drain();

    // phase 3: both sides idle now and then
    @(negedge clk);
    send_gap_pct   = 27;
    recv_stall_pct = 27;
    queue_random_words(WORDS_PER_PHASE);
    drain();

    // two-stage pipeline: a final wait catches any stray result word
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #(2_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
